// File: rtl/ipfr_pkg.sv
// ----------------------------------------------------------------------------
// ipfr_pkg
// Shared constants, register codes and types for the IR pulse frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipfr_pkg;

  // Frame buffer size in bytes; the byte counter saturates here.
  localparam int BUF_BYTES = 512;
  localparam int BC_W      = $clog2(BUF_BYTES + 1);

  localparam int TIME_W  = 32;
  localparam int CFG_W   = 16;
  localparam int MAXP_W  = 9;
  localparam int IDX_W   = 9;
  localparam int REG_IDX_W = 3;

  // Length header: (blocks - 1) * LEN_BLOCK + remainder, then LEN_HDR header bytes
  localparam int LEN_BLOCK = 32;
  localparam int LEN_HDR   = 2;
  localparam int LEN_SHIFT = $clog2(LEN_BLOCK);
  localparam int LEN_W     = 8 + LEN_SHIFT + 1;
  localparam int CMP_W     = (LEN_W > BC_W) ? LEN_W + 1 : BC_W + 1;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_HDR_MARK_MIN  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HDR_MARK_MAX  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HDR_SPACE_MIN = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HDR_SPACE_MAX = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INTERVAL_FLOOR = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BIT_THRESHOLD = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MAX_PAYLOAD   = 3'd6;

  // Receiver phases
  localparam logic [1:0] PH_HDR_MARK   = 2'd0;
  localparam logic [1:0] PH_HDR_SPACE  = 2'd1;
  localparam logic [1:0] PH_DATA_MARK  = 2'd2;
  localparam logic [1:0] PH_DATA_SPACE = 2'd3;

  // Request types
  localparam logic REQ_EDGE    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0]  header_mark_min;
    logic [CFG_W-1:0]  header_mark_max;
    logic [CFG_W-1:0]  header_space_min;
    logic [CFG_W-1:0]  header_space_max;
    logic [CFG_W-1:0]  interval_floor;
    logic [CFG_W-1:0]  bit_threshold;
    logic [MAXP_W-1:0] max_payload;
  } cfg_t;

endpackage

`default_nettype wire

// File: rtl/ipfr_if.sv
// ----------------------------------------------------------------------------
// ipfr_if
// Valid/ready channels for edge requests and per-edge receiver results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ipfr_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] edge_time_us;

  modport source (output valid, req_type, edge_time_us, input ready);
  modport sink   (input valid, req_type, edge_time_us, output ready);
endinterface

interface ipfr_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] byte_value;
  logic [8:0] byte_index;
  logic       receiving;
  logic       data_ready;
  logic       size_error;
  logic       timing_reset;
  logic [1:0] phase;

  modport source (output valid, byte_valid, byte_value, byte_index, receiving,
                  data_ready, size_error, timing_reset, phase, input ready);
  modport sink   (input valid, byte_valid, byte_value, byte_index, receiving,
                  data_ready, size_error, timing_reset, phase, output ready);
endinterface

`default_nettype wire

// File: rtl/ir_pulse_frame_receiver.sv
// ----------------------------------------------------------------------------
// ir_pulse_frame_receiver
// IR pulse-width frame receiver: edge timing checks, bit decode, byte output.
// ----------------------------------------------------------------------------
// An accepted edge's result is written straight into the output register.
// Throughput: one edge per cycle while out_ch.ready holds; the decoder state updates in the accept cycle.
// The input is ready whenever the output register is empty or being drained.
// Reset (rst, synchronous): config registers take their defaults, decoder state
// and last edge time clear, and the output register empties.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_frame_receiver
  import ipfr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  ipfr_in_if.sink                   in_ch,
  ipfr_out_if.source                out_ch
);

  cfg_t cfg;

  ipfr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Decoder state
  logic [1:0]        phase,       phase_next;
  logic [TIME_W-1:0] last_time,   last_time_next;
  logic [7:0]        bit_shift,   bit_shift_next;
  logic [2:0]        bit_count,   bit_count_next;
  logic [BC_W-1:0]   byte_count,  byte_count_next;
  logic [7:0]        len_blocks,  len_blocks_next;
  logic [7:0]        len_rem,     len_rem_next;

  // Per-edge results
  logic              res_byte_valid;
  logic [7:0]        res_byte_value;
  logic [IDX_W-1:0]  res_byte_index;
  logic              res_treset;
  logic              res_recv;
  logic              res_ready;
  logic              res_serr;

  logic              accept;
  logic [TIME_W-1:0] diff;
  logic              bad_interval;
  logic              data_bit;
  logic [7:0]        shift_in;
  logic [2:0]        count_inc;
  logic [LEN_W-1:0]  len_biased;   // declared length + LEN_BLOCK
  logic [CMP_W-1:0]  len_cmp;
  logic [CMP_W-1:0]  max_cmp;
  logic [CMP_W-1:0]  have_cmp;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign diff      = in_ch.edge_time_us - last_time;
  assign bad_interval = ((diff > TIME_W'(cfg.header_mark_max)) && !phase[1]) ||
                        (diff < TIME_W'(cfg.interval_floor));
  assign data_bit  = diff > TIME_W'(cfg.bit_threshold);
  assign shift_in  = {bit_shift[6:0], data_bit};
  assign count_inc = bit_count + 3'd1;

  always_comb begin
    phase_next      = phase;
    last_time_next  = last_time;
    bit_shift_next  = bit_shift;
    bit_count_next  = bit_count;
    byte_count_next = byte_count;
    len_blocks_next = len_blocks;
    len_rem_next    = len_rem;
    res_byte_valid  = 1'b0;
    res_byte_value  = '0;
    res_byte_index  = '0;
    res_treset      = 1'b0;

    if (in_ch.req_type == REQ_RESTART) begin
      phase_next      = PH_HDR_MARK;
      bit_shift_next  = '0;
      bit_count_next  = '0;
      byte_count_next = '0;
      len_blocks_next = '0;
      len_rem_next    = '0;
    end else begin
      last_time_next = in_ch.edge_time_us;
      if ((last_time == '0) || (last_time > in_ch.edge_time_us) || bad_interval) begin
        res_treset = 1'b1;
      end else begin
        unique case (phase)
          PH_HDR_MARK: begin
            if (diff >= TIME_W'(cfg.header_mark_min)) begin
              phase_next = PH_HDR_SPACE;
            end else begin
              res_treset = 1'b1;
            end
          end
          PH_HDR_SPACE: begin
            if ((diff >= TIME_W'(cfg.header_space_min)) &&
                (diff <= TIME_W'(cfg.header_space_max))) begin
              phase_next = PH_DATA_MARK;
            end else begin
              res_treset = 1'b1;
            end
          end
          PH_DATA_MARK: begin
            phase_next = PH_DATA_SPACE;
            // bits past a full buffer are dropped
            if (byte_count < BC_W'(BUF_BYTES)) begin
              bit_shift_next = shift_in;
              bit_count_next = count_inc;
              if (count_inc == 3'd0) begin
                res_byte_valid  = 1'b1;
                res_byte_value  = shift_in;
                res_byte_index  = IDX_W'(byte_count);
                bit_shift_next  = '0;
                byte_count_next = byte_count + BC_W'(1);
                if (byte_count == BC_W'(0)) begin
                  len_blocks_next = shift_in;
                end
                if (byte_count == BC_W'(1)) begin
                  len_rem_next = shift_in;
                end
              end
            end
          end
          PH_DATA_SPACE: begin
            phase_next = PH_DATA_MARK;
          end
          default: ;
        endcase
      end
      if (res_treset) begin
        phase_next      = PH_HDR_MARK;
        bit_shift_next  = '0;
        bit_count_next  = '0;
        byte_count_next = '0;
        len_blocks_next = '0;
        len_rem_next    = '0;
      end
    end
  end

  // Length checks on the updated state, with the length biased by one block
  // so everything stays unsigned: length <= 0 means biased <= LEN_BLOCK.
  assign len_biased = {1'b0, len_blocks_next, {LEN_SHIFT{1'b0}}} + LEN_W'(len_rem_next);
  assign len_cmp    = CMP_W'(len_biased);
  assign max_cmp    = CMP_W'(cfg.max_payload) + CMP_W'(LEN_BLOCK);
  assign have_cmp   = CMP_W'(byte_count_next) + CMP_W'(LEN_BLOCK - LEN_HDR);

  assign res_recv  = byte_count_next > BC_W'(LEN_HDR);
  assign res_serr  = res_recv && ((len_cmp <= CMP_W'(LEN_BLOCK)) || (len_cmp > max_cmp));
  assign res_ready = res_recv && !res_serr && (have_cmp >= len_cmp);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR_MARK;
      last_time  <= '0;
      bit_shift  <= '0;
      bit_count  <= '0;
      byte_count <= '0;
      len_blocks <= '0;
      len_rem    <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      last_time  <= last_time_next;
      bit_shift  <= bit_shift_next;
      bit_count  <= bit_count_next;
      byte_count <= byte_count_next;
      len_blocks <= len_blocks_next;
      len_rem    <= len_rem_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (accept) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.byte_valid   <= res_byte_valid;
      out_ch.byte_value   <= res_byte_value;
      out_ch.byte_index   <= res_byte_index;
      out_ch.receiving    <= res_recv;
      out_ch.data_ready   <= res_ready;
      out_ch.size_error   <= res_serr;
      out_ch.timing_reset <= res_treset;
      out_ch.phase        <= phase_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ipfr_regs.sv
// ----------------------------------------------------------------------------
// ipfr_regs
// Configuration register file with write-only access.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipfr_regs
  import ipfr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_mark_min  <= CFG_W'(2000);
      cfg.header_mark_max  <= CFG_W'(4000);
      cfg.header_space_min <= CFG_W'(1000);
      cfg.header_space_max <= CFG_W'(2000);
      cfg.interval_floor   <= CFG_W'(100);
      cfg.bit_threshold    <= CFG_W'(1000);
      cfg.max_payload      <= MAXP_W'(510);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HDR_MARK_MIN:   cfg.header_mark_min  <= cfg_data;
        REG_HDR_MARK_MAX:   cfg.header_mark_max  <= cfg_data;
        REG_HDR_SPACE_MIN:  cfg.header_space_min <= cfg_data;
        REG_HDR_SPACE_MAX:  cfg.header_space_max <= cfg_data;
        REG_INTERVAL_FLOOR: cfg.interval_floor   <= cfg_data;
        REG_BIT_THRESHOLD:  cfg.bit_threshold    <= cfg_data;
        REG_MAX_PAYLOAD:    cfg.max_payload      <= cfg_data[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ir_pulse_frame_receiver. A short table of timing
// corner cases runs first, then random IR frames (header, length bytes,
// payload) with some noise, under several register settings. Near the end
// one frame long enough to fill the byte buffer runs. Every edge result is checked
// against a local decoder model, or against the table for typed table rows.
// ----------------------------------------------------------------------------
module tb;
  import ipfr_pkg::*;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_value;
    logic [8:0] byte_index;
    logic       receiving;
    logic       data_ready;
    logic       size_error;
    logic       timing_reset;
    logic [1:0] phase;
  } rx_result_t;

  typedef struct {
    logic        req;
    bit          rel;    // val is a delta from the last edge time
    logic [31:0] val;
    bit          typed;  // res holds the expected result
    rx_result_t  res;
  } stim_row_t;

  typedef enum int {PACE_OPEN, PACE_COIN, PACE_EVERY4, PACE_MOSTLY} pace_t;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 300;

  localparam rx_result_t RES_IDLE =
    '{1'b0, 8'd0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b0, PH_HDR_MARK};
  localparam rx_result_t RES_TRESET =
    '{1'b0, 8'd0, 9'd0, 1'b0, 1'b0, 1'b0, 1'b1, PH_HDR_MARK};

  stim_row_t timing_rows [22] = '{
    '{REQ_EDGE,    1'b0, 32'h0000_0000, 1'b1, RES_TRESET},  // no previous edge
    '{REQ_EDGE,    1'b0, 32'hFFFF_FFFF, 1'b1, RES_TRESET},
    '{REQ_EDGE,    1'b0, 32'h0000_1000, 1'b1, RES_TRESET},  // time went backward
    '{REQ_RESTART, 1'b0, 32'hFFFF_FFFF, 1'b1, RES_IDLE},
    '{REQ_EDGE,    1'b1, 32'd99,        1'b1, RES_TRESET},  // below floor
    '{REQ_EDGE,    1'b1, 32'd1999,      1'b1, RES_TRESET},  // header mark short
    '{REQ_EDGE,    1'b1, 32'd4001,      1'b1, RES_TRESET},  // header mark long
    '{REQ_EDGE,    1'b1, 32'd2000,      1'b0, RES_IDLE},
    '{REQ_EDGE,    1'b1, 32'd999,       1'b1, RES_TRESET},  // header space short
    '{REQ_EDGE,    1'b1, 32'd4000,      1'b0, RES_IDLE},
    '{REQ_EDGE,    1'b1, 32'd2001,      1'b1, RES_TRESET},  // header space long
    '{REQ_EDGE,    1'b1, 32'd3000,      1'b0, RES_IDLE},
    '{REQ_EDGE,    1'b1, 32'd2000,      1'b0, RES_IDLE},
    '{REQ_EDGE,    1'b1, 32'd1000,      1'b0, RES_IDLE},    // mark at threshold
    '{REQ_EDGE,    1'b1, 32'd100,       1'b0, RES_IDLE},
    '{REQ_EDGE,    1'b1, 32'd1001,      1'b0, RES_IDLE},
    '{REQ_EDGE,    1'b1, 32'd70000,     1'b0, RES_IDLE},    // long data space
    '{REQ_EDGE,    1'b1, 32'h0100_0000, 1'b0, RES_IDLE},    // huge data mark
    '{REQ_EDGE,    1'b1, 32'd99,        1'b1, RES_TRESET},
    '{REQ_EDGE,    1'b1, 32'd3000,      1'b0, RES_IDLE},
    '{REQ_RESTART, 1'b0, 32'hA5A5_5A5A, 1'b1, RES_IDLE},
    '{REQ_EDGE,    1'b1, 32'd0,         1'b1, RES_TRESET}   // zero interval
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  ipfr_in_if  in_ch ();
  ipfr_out_if out_ch ();

  ir_pulse_frame_receiver u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder model state
  cfg_t        m_cfg;
  logic [1:0]  m_phase;
  logic [31:0] m_last;
  logic [7:0]  m_shift;
  logic [2:0]  m_bits;
  int unsigned m_bytes;
  logic [7:0]  m_blocks;
  logic [7:0]  m_rem;

  rx_result_t  pending_results [$];
  logic [31:0] cur_time;
  int          burst_left;
  int unsigned edges_sent;
  int unsigned noise_pct;
  int unsigned mismatches;
  int unsigned results_seen;
  bit          hold_off_req;

  function automatic int unsigned umax(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

  function automatic int unsigned umin(input int unsigned a, input int unsigned b);
    return (a < b) ? a : b;
  endfunction

  function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
    return (lo >= hi) ? lo : $urandom_range(hi, lo);
  endfunction

  function automatic cfg_t make_cfg(input int unsigned hmin, input int unsigned hmax,
                                    input int unsigned smin, input int unsigned smax,
                                    input int unsigned floor_us, input int unsigned thr,
                                    input int unsigned maxp);
    cfg_t c;
    c.header_mark_min  = hmin[CFG_W-1:0];
    c.header_mark_max  = hmax[CFG_W-1:0];
    c.header_space_min = smin[CFG_W-1:0];
    c.header_space_max = smax[CFG_W-1:0];
    c.interval_floor   = floor_us[CFG_W-1:0];
    c.bit_threshold    = thr[CFG_W-1:0];
    c.max_payload      = maxp[MAXP_W-1:0];
    return c;
  endfunction

  function automatic void clear_rx();
    m_phase  = PH_HDR_MARK;
    m_shift  = '0;
    m_bits   = '0;
    m_bytes  = 0;
    m_blocks = '0;
    m_rem    = '0;
  endfunction

  function automatic rx_result_t decode_edge(input logic req, input logic [31:0] t);
    rx_result_t  r;
    logic [31:0] diff;
    int          total;
    r = RES_IDLE;
    if (req == REQ_RESTART) begin
      clear_rx();
    end else if (m_last == 32'd0 || m_last > t) begin
      m_last = t;
      clear_rx();
      r.timing_reset = 1'b1;
    end else begin
      diff   = t - m_last;
      m_last = t;
      if ((diff > m_cfg.header_mark_max && m_phase < PH_DATA_MARK) ||
          diff < m_cfg.interval_floor) begin
        clear_rx();
        r.timing_reset = 1'b1;
      end else begin
        case (m_phase)
          PH_HDR_MARK: begin
            if (diff >= m_cfg.header_mark_min && diff <= m_cfg.header_mark_max) begin
              m_phase = PH_HDR_SPACE;
            end else begin
              clear_rx();
              r.timing_reset = 1'b1;
            end
          end
          PH_HDR_SPACE: begin
            if (diff >= m_cfg.header_space_min && diff <= m_cfg.header_space_max) begin
              m_phase = PH_DATA_MARK;
            end else begin
              clear_rx();
              r.timing_reset = 1'b1;
            end
          end
          PH_DATA_MARK: begin
            // buffer full: the bit is dropped but the phase still advances
            if (m_bytes < BUF_BYTES) begin
              m_shift = {m_shift[6:0], (diff > m_cfg.bit_threshold)};
              m_bits  = m_bits + 3'd1;
              if (m_bits == 3'd0) begin
                r.byte_valid = 1'b1;
                r.byte_value = m_shift;
                r.byte_index = 9'(m_bytes);
                if (m_bytes == 0) begin
                  m_blocks = m_shift;
                end else if (m_bytes == 1) begin
                  m_rem = m_shift;
                end
                m_bytes = m_bytes + 1;
                m_shift = '0;
              end
            end
            m_phase = PH_DATA_SPACE;
          end
          default: m_phase = PH_DATA_MARK;
        endcase
      end
    end
    r.receiving = (m_bytes > LEN_HDR);
    if (r.receiving) begin
      total = (int'(m_blocks) - 1) * LEN_BLOCK + int'(m_rem);
      if (total <= 0 || total > int'(m_cfg.max_payload)) begin
        r.size_error = 1'b1;
      end else if (int'(m_bytes) >= total + LEN_HDR) begin
        r.data_ready = 1'b1;
      end
    end
    r.phase = m_phase;
    return r;
  endfunction

  task automatic send_item(input logic req, input logic [31:0] t, input bit typed,
                           input rx_result_t typed_res);
    rx_result_t r;
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= req;
    in_ch.edge_time_us <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = decode_edge(req, t);
    pending_results.push_back(typed ? typed_res : r);
    edges_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(4, 0) == 0) ? 300 : $urandom_range(40, 1);
    end
  endtask

  task automatic step_edge(input logic [31:0] delta);
    if ($urandom_range(99, 0) < noise_pct) begin
      if ($urandom_range(1, 0)) begin
        send_item(REQ_RESTART, $urandom, 1'b0, RES_IDLE);
      end else begin
        cur_time = cur_time + $urandom_range(70000, 0);
        send_item(REQ_EDGE, cur_time, 1'b0, RES_IDLE);
      end
    end
    cur_time = cur_time + delta;
    send_item(REQ_EDGE, cur_time, 1'b0, RES_IDLE);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned lo;
    for (int i = 7; i >= 0; i--) begin
      if (b[i] || m_cfg.interval_floor > m_cfg.bit_threshold) begin
        lo = umax(m_cfg.bit_threshold + 1, m_cfg.interval_floor);
        step_edge(pick(lo, lo + 3000));
      end else begin
        step_edge(pick(m_cfg.interval_floor, m_cfg.bit_threshold));
      end
      step_edge(pick(m_cfg.interval_floor, m_cfg.interval_floor + 2000));
    end
  endtask

  task automatic send_frame(input bit long_form);
    int unsigned sel;
    int unsigned total;
    int unsigned n_pay;
    logic [7:0]  blocks;
    logic [7:0]  rem;
    // get back to the header mark phase; sometimes skip that on purpose
    sel = long_form ? 0 : $urandom_range(9, 0);
    case (sel)
      6: begin
        if (cur_time > 1) begin
          cur_time = $urandom_range(cur_time - 1, 1);
          send_item(REQ_EDGE, cur_time, 1'b0, RES_IDLE);
        end else begin
          send_item(REQ_RESTART, $urandom, 1'b0, RES_IDLE);
        end
      end
      7: begin
        cur_time = $urandom;
        send_item(REQ_EDGE, cur_time, 1'b0, RES_IDLE);
        send_item(REQ_RESTART, $urandom, 1'b0, RES_IDLE);
      end
      8: begin
        if (m_cfg.interval_floor > 0) begin
          step_edge(pick(0, m_cfg.interval_floor - 1));
        end else begin
          send_item(REQ_RESTART, $urandom, 1'b0, RES_IDLE);
        end
      end
      9: ;
      default: send_item(REQ_RESTART, $urandom, 1'b0, RES_IDLE);
    endcase

    step_edge(pick(umax(m_cfg.header_mark_min, m_cfg.interval_floor),
                   m_cfg.header_mark_max));
    step_edge(pick(umax(m_cfg.header_space_min, m_cfg.interval_floor),
                   umin(m_cfg.header_space_max, m_cfg.header_mark_max)));

    sel = $urandom_range(9, 0);
    if (long_form) begin
      blocks = 8'd16;
      rem    = 8'd30;
      n_pay  = 513;
    end else if (sel < 7) begin
      total = $urandom_range(umin(m_cfg.max_payload, 8), 1);
      if ($urandom_range(1, 0)) begin
        blocks = 8'(total / LEN_BLOCK + 1);
        rem    = 8'(total % LEN_BLOCK);
      end else begin
        blocks = 8'd1;
        rem    = 8'(total);
      end
      n_pay = total + $urandom_range(3, 0) - 1;
    end else if (sel == 7) begin
      blocks = 8'd0;
      rem    = 8'($urandom_range(255, 0));
      n_pay  = $urandom_range(4, 1);
    end else if (sel == 8) begin
      total  = $urandom_range(1, 0) ? m_cfg.max_payload + 1 : $urandom_range(8000, 512);
      blocks = 8'(total / LEN_BLOCK + 1);
      rem    = 8'(total % LEN_BLOCK);
      n_pay  = $urandom_range(4, 1);
    end else begin
      blocks = 8'($urandom_range(255, 0));
      rem    = 8'($urandom_range(255, 0));
      n_pay  = $urandom_range(4, 0);
    end
    send_byte(blocks);
    send_byte(rem);
    repeat (n_pay) send_byte(8'($urandom_range(255, 0)));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_config(input cfg_t c);
    logic [REG_IDX_W-1:0] regs [8] = '{REG_HDR_MARK_MIN, REG_HDR_MARK_MAX,
                                       REG_HDR_SPACE_MIN, REG_HDR_SPACE_MAX,
                                       REG_INTERVAL_FLOOR, REG_BIT_THRESHOLD,
                                       REG_MAX_PAYLOAD, REG_UNUSED};
    logic [CFG_W-1:0]     vals [8];
    logic [6:0]           junk;
    junk    = 7'($urandom_range(127, 0));
    vals[0] = c.header_mark_min;
    vals[1] = c.header_mark_max;
    vals[2] = c.header_space_min;
    vals[3] = c.header_space_max;
    vals[4] = c.interval_floor;
    vals[5] = c.bit_threshold;
    vals[6] = {junk, c.max_payload};   // upper bits are don't-care
    vals[7] = CFG_W'($urandom_range(65535, 0));
    for (int k = 0; k < 8; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_cfg = c;
  endtask

  task automatic run_frames(input int unsigned budget);
    int unsigned stop_at;
    stop_at = edges_sent + budget;
    while (edges_sent < stop_at) send_frame(1'b0);
    settle();
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on %s, result %0d: expected %0d, got %0d",
                 name, results_seen, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    rx_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d arrived with none pending", results_seen);
      end else begin
        want = pending_results.pop_front();
        report_field("byte_valid",   want.byte_valid,   out_ch.byte_valid);
        report_field("byte_value",   want.byte_value,   out_ch.byte_value);
        report_field("byte_index",   want.byte_index,   out_ch.byte_index);
        report_field("receiving",    want.receiving,    out_ch.receiving);
        report_field("data_ready",   want.data_ready,   out_ch.data_ready);
        report_field("size_error",   want.size_error,   out_ch.size_error);
        report_field("timing_reset", want.timing_reset, out_ch.timing_reset);
        report_field("phase",        want.phase,        out_ch.phase);
      end
      results_seen++;
    end
  end

  // output side pacing, plus one long hold-off on request
  initial begin : sink_pace
    pace_t pace;
    int    seg_left;
    int    hold_left;
    out_ch.ready = 1'b0;
    pace         = PACE_OPEN;
    seg_left     = 0;
    hold_left    = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          pace     = pace_t'($urandom_range(3, 0));
          seg_left = $urandom_range(200, 20);
        end
        seg_left--;
        case (pace)
          PACE_OPEN:   out_ch.ready <= 1'b1;
          PACE_COIN:   out_ch.ready <= ($urandom_range(1, 0) != 0);
          PACE_EVERY4: out_ch.ready <= (seg_left % 4 == 0);
          default:     out_ch.ready <= ($urandom_range(7, 0) != 0);
        endcase
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] t;
    int unsigned hmin;
    int unsigned smin;
    int unsigned floor_us;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_EDGE;
    in_ch.edge_time_us = '0;
    hold_off_req       = 1'b0;
    mismatches         = 0;
    results_seen       = 0;
    edges_sent         = 0;
    noise_pct          = 0;
    burst_left         = 1;
    cur_time           = '0;
    m_cfg              = make_cfg(2000, 4000, 1000, 2000, 100, 1000, 510);
    m_last             = '0;
    clear_rx();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (timing_rows[i]) begin
      t = timing_rows[i].rel ? cur_time + timing_rows[i].val : timing_rows[i].val;
      if (timing_rows[i].req == REQ_EDGE) cur_time = t;
      send_item(timing_rows[i].req, t, timing_rows[i].typed, timing_rows[i].res);
    end
    settle();

    noise_pct = 2;
    load_config(make_cfg(2500, 5000, 1200, 2400, 150, 800, 20));
    hold_off_req = 1'b1;
    run_frames(350);

    // low extremes: zero minimums, floor and threshold, with maximums at 65535
    load_config(make_cfg(0, 65535, 0, 65535, 0, 0, 1));
    run_frames(250);

    // high extremes: only 65535-us headers pass
    load_config(make_cfg(65535, 65535, 65535, 65535, 65535, 65535, 510));
    run_frames(200);

    hmin     = $urandom_range(3000, 500);
    smin     = $urandom_range(2000, 100);
    floor_us = $urandom_range(300, 0);
    load_config(make_cfg(hmin, umin(hmin + $urandom_range(3000, 0), 65535),
                         smin, smin + $urandom_range(2000, 0), floor_us,
                         $urandom_range(2000, floor_us), $urandom_range(510, 1)));
    run_frames(250);

    load_config(make_cfg($urandom_range(65535, 0), $urandom_range(65535, 0),
                         $urandom_range(65535, 0), $urandom_range(65535, 0),
                         $urandom_range(65535, 0), $urandom_range(65535, 0),
                         $urandom_range(510, 1)));
    run_frames(150);

    // one clean maximum-length frame that runs past the buffer end
    noise_pct = 0;
    load_config(make_cfg(2000, 4000, 1000, 2000, 100, 1000, 510));
    send_frame(1'b1);
    noise_pct = 2;
    run_frames(150);

    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ipfr_pkg.sv
rtl/ipfr_if.sv
rtl/ipfr_regs.sv
rtl/ir_pulse_frame_receiver.sv
test/tb.sv
